FILE: design/nct_pkg.sv
// shared types, codes and defaults for the nat connection table
`default_nettype none
package nct_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FULL    = 3'd2,
		ST_HIT     = 3'd3,
		ST_MISS    = 3'd4
	} status_t;

	// item travelling down the cell chain, with the match collected so far
	typedef struct packed {
		logic        valid;
		logic        op;
		logic [31:0] sa;
		logic [15:0] sp;
		logic [31:0] da;
		logic [15:0] dp;
		logic [31:0] ra;
		logic [15:0] rp;
		logic        hit;
		logic [31:0] fda;
		logic [15:0] fdp;
	} token_t;

endpackage
`default_nettype wire

FILE: design/nct_item_if.sv
// input channel: one add or lookup item per beat
`default_nettype none
interface nct_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] source_address;
	logic [15:0] source_port;
	logic [31:0] dest_address;
	logic [15:0] dest_port;
	logic [31:0] redirect_address;
	logic [15:0] redirect_port;

	modport source (
		output valid, operation, source_address, source_port, dest_address, dest_port,
			redirect_address, redirect_port,
		input ready
	);
	modport sink (
		input valid, operation, source_address, source_port, dest_address, dest_port,
			redirect_address, redirect_port,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/nct_result_if.sv
// output channel: one status and found tuple per beat
`default_nettype none
interface nct_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] found_source_address;
	logic [15:0] found_source_port;
	logic [31:0] found_dest_address;
	logic [15:0] found_dest_port;

	modport source (
		output valid, status, found_source_address, found_source_port, found_dest_address,
			found_dest_port,
		input ready
	);
	modport sink (
		input valid, status, found_source_address, found_source_port, found_dest_address,
			found_dest_port,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/nct_cell.sv
// one table entry: compares the passing item, captures it on append
`default_nettype none
module nct_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [CNT_W-1:0]   count,
	input  wire nct_pkg::token_t    tok_in,
	output nct_pkg::token_t         tok_out
);
	import nct_pkg::*;

	logic [31:0] ent_sa_q;
	logic [15:0] ent_sp_q;
	logic [31:0] ent_da_q;
	logic [15:0] ent_dp_q;
	logic [31:0] ent_ra_q;
	logic [15:0] ent_rp_q;

	token_t tok_q;
	logic   valid_q;
	logic   used;
	logic   src_eq;
	logic   match;
	logic   take;

	assign used   = CNT_W'(IDX) < count;
	assign src_eq = (ent_sa_q == tok_in.sa) && (ent_sp_q == tok_in.sp);

	always_comb begin
		if (tok_in.op == OP_ADD) begin
			match = used && src_eq && (ent_da_q == tok_in.da) && (ent_dp_q == tok_in.dp);
		end else begin
			match = used && src_eq && (ent_rp_q == tok_in.dp)
				&& ((ent_ra_q == tok_in.da) || (tok_in.da == 32'd0));
		end
	end

	// first free slot takes a new tuple if no earlier entry matched
	assign take = en && tok_in.valid && (tok_in.op == OP_ADD) && !tok_in.hit
		&& (count == CNT_W'(IDX));

	always_ff @(posedge clk) begin
		if (take) begin
			ent_sa_q <= tok_in.sa;
			ent_sp_q <= tok_in.sp;
			ent_da_q <= tok_in.da;
			ent_dp_q <= tok_in.dp;
			ent_ra_q <= tok_in.ra;
			ent_rp_q <= tok_in.rp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q.valid <= tok_in.valid;
			tok_q.op    <= tok_in.op;
			tok_q.sa    <= tok_in.sa;
			tok_q.sp    <= tok_in.sp;
			tok_q.da    <= tok_in.da;
			tok_q.dp    <= tok_in.dp;
			tok_q.ra    <= tok_in.ra;
			tok_q.rp    <= tok_in.rp;
			tok_q.hit   <= tok_in.hit || match;
			if (!tok_in.hit && match) begin
				tok_q.fda <= ent_da_q;
				tok_q.fdp <= ent_dp_q;
			end else begin
				tok_q.fda <= tok_in.fda;
				tok_q.fdp <= tok_in.fdp;
			end
		end
	end

	// the reset copy of valid goes out with the beat
	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule
`default_nettype wire

FILE: design/nat_connection_table_top.sv
// nat connection table: chain of entry cells, counter and result register
//
//  channel  dir  beat
//  item     in   operation, tuple, redirect address and port
//  result   out  status, found source and destination
//
// an item walks the chain one cell per cycle unless a result not taken stalls it;
// one item is in flight at a time.
// reset clears the entry count and all control; entry contents are not cleared.
// a result not taken holds the item at the chain end; a new item is accepted
// as soon as the previous result sits in the output register.
`default_nettype none
module nat_connection_table_top #(
	parameter int TABLE_DEPTH = nct_pkg::TABLE_DEPTH_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	nct_item_if.sink     item,
	nct_result_if.source result
);
	import nct_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	token_t tok [TABLE_DEPTH+1];

	logic             busy_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [31:0]      fsa_q;
	logic [15:0]      fsp_q;
	logic [31:0]      fda_q;
	logic [15:0]      fdp_q;

	logic    accept;
	logic    move;
	logic    en;
	logic    full;
	token_t  last;
	status_t status_d;

	assign item.ready = !busy_q;
	assign accept     = item.valid && !busy_q;

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = accept;
		tok[0].op    = item.operation;
		tok[0].sa    = item.source_address;
		tok[0].sp    = item.source_port;
		tok[0].da    = item.dest_address;
		tok[0].dp    = item.dest_port;
		tok[0].ra    = item.redirect_address;
		tok[0].rp    = item.redirect_port;
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		nct_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.count   (count_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign last = tok[TABLE_DEPTH];
	assign full = count_q == CNT_W'(TABLE_DEPTH);
	assign move = last.valid && (!out_valid_q || result.ready);
	assign en   = !last.valid || move;

	always_comb begin
		if (last.op == OP_ADD) begin
			if (last.hit) begin
				status_d = ST_PRESENT;
			end else if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_ADDED;
			end
		end else begin
			status_d = last.hit ? ST_HIT : ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (move && last.op == OP_ADD && !last.hit && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			status_q <= status_d;
			if (last.op == OP_LOOKUP && last.hit) begin
				fsa_q <= last.sa;
				fsp_q <= last.sp;
				fda_q <= last.fda;
				fdp_q <= last.fdp;
			end else begin
				fsa_q <= '0;
				fsp_q <= '0;
				fda_q <= '0;
				fdp_q <= '0;
			end
		end
	end

	assign result.valid                = out_valid_q;
	assign result.status               = status_q;
	assign result.found_source_address = fsa_q;
	assign result.found_source_port    = fsp_q;
	assign result.found_dest_address   = fda_q;
	assign result.found_dest_port      = fdp_q;

endmodule
`default_nettype wire
